>>> rtl/qpr_pkg.sv
// ============================================================================
// qpr_pkg: shared types and constants of the quaternion point rotator
// Widths of the quaternion, coordinate and matrix datapaths, register indexes.
// ============================================================================
package qpr_pkg;

  // Field widths
  localparam int unsigned QuatW  = 16;   // quaternion component, Q1.14
  localparam int unsigned CoordW = 32;   // coordinate, Q19.12
  localparam int unsigned QProdW = 2 * QuatW;      // component product, Q.28
  localparam int unsigned EntExW = QProdW + 3;     // exact matrix entry, Q.28
  localparam int unsigned EntW   = 26;             // rounded matrix entry, Q.20
  localparam int unsigned ProdW  = EntW + CoordW;  // entry x coordinate, Q.32
  localparam int unsigned SumW   = ProdW + 2;      // sum of three products
  localparam int unsigned EntSh  = 8;              // Q.28 -> Q.20
  localparam int unsigned OutSh  = 20;             // Q.32 -> Q.12
  localparam int unsigned RndW   = SumW - OutSh;   // rounded sum width

  localparam logic signed [EntExW-1:0] OneQ28  = EntExW'(64'sd1 <<< 28);
  localparam logic signed [EntExW-1:0] EntRnd  = EntExW'(64'sd1 <<< (EntSh - 1));
  localparam logic signed [SumW-1:0]   OutRnd  = SumW'(64'sd1 <<< (OutSh - 1));
  localparam logic signed [CoordW-1:0] CrdMax  = {1'b0, {(CoordW - 1){1'b1}}};
  localparam logic signed [CoordW-1:0] CrdMin  = {1'b1, {(CoordW - 1){1'b0}}};

  localparam logic [QuatW-1:0] QuatWReset = 16'h4000;  // 1.0 in Q1.14

  typedef logic signed [QuatW-1:0]  quat_c_t;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [EntW-1:0]   ent_t;

  typedef struct packed {
    quat_c_t w;
    quat_c_t x;
    quat_c_t y;
    quat_c_t z;
  } quat_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_QUAT_W = 2'd0,
    CFG_QUAT_X = 2'd1,
    CFG_QUAT_Y = 2'd2,
    CFG_QUAT_Z = 2'd3
  } cfg_idx_e;

endpackage

>>> rtl/qpr_quat_mat.sv
// ============================================================================
// qpr_quat_mat: rotation matrix from the quaternion, two pipeline stages
// Stage one forms the component products, stage two the rounded entries.
// ============================================================================
module qpr_quat_mat import qpr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  quat_t  quat_i,
  input  coord_t coord_i [3],
  output logic   valid_o,
  input  logic   ready_i,
  output ent_t   ent_o [3][3],
  output coord_t coord_o [3]
);

  typedef logic signed [QProdW-1:0] qprod_t;
  typedef logic signed [EntExW-1:0] entex_t;

  // Stage 1 registers
  logic   v1_q;
  qprod_t xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  coord_t c1_q [3];
  // Stage 2 registers
  logic   v2_q;
  ent_t   ent_q [3][3];
  coord_t c2_q [3];

  logic   adv1, adv2;
  ent_t   ent_d [3][3];

  function automatic ent_t round_ent(entex_t e);
    entex_t t;
    t = e + EntRnd;
    return t[EntSh +: EntW];
  endfunction

  function automatic entex_t twice(qprod_t a, qprod_t b, logic sub);
    entex_t s;
    s = sub ? (EntExW'(a) - EntExW'(b)) : (EntExW'(a) + EntExW'(b));
    return s <<< 1;
  endfunction

  assign adv2    = !v2_q || ready_i;
  assign adv1    = !v1_q || adv2;
  assign ready_o = adv1;

  always_comb begin
    ent_d[0][0] = round_ent(OneQ28 - twice(yy_q, zz_q, 1'b0));
    ent_d[0][1] = round_ent(twice(xy_q, wz_q, 1'b1));
    ent_d[0][2] = round_ent(twice(xz_q, wy_q, 1'b0));
    ent_d[1][0] = round_ent(twice(xy_q, wz_q, 1'b0));
    ent_d[1][1] = round_ent(OneQ28 - twice(xx_q, zz_q, 1'b0));
    ent_d[1][2] = round_ent(twice(yz_q, wx_q, 1'b1));
    ent_d[2][0] = round_ent(twice(xz_q, wy_q, 1'b1));
    ent_d[2][1] = round_ent(twice(yz_q, wx_q, 1'b0));
    ent_d[2][2] = round_ent(OneQ28 - twice(xx_q, yy_q, 1'b0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      xx_q <= QProdW'(quat_i.x) * QProdW'(quat_i.x);
      yy_q <= QProdW'(quat_i.y) * QProdW'(quat_i.y);
      zz_q <= QProdW'(quat_i.z) * QProdW'(quat_i.z);
      xy_q <= QProdW'(quat_i.x) * QProdW'(quat_i.y);
      xz_q <= QProdW'(quat_i.x) * QProdW'(quat_i.z);
      yz_q <= QProdW'(quat_i.y) * QProdW'(quat_i.z);
      wx_q <= QProdW'(quat_i.w) * QProdW'(quat_i.x);
      wy_q <= QProdW'(quat_i.w) * QProdW'(quat_i.y);
      wz_q <= QProdW'(quat_i.w) * QProdW'(quat_i.z);
      c1_q <= coord_i;
    end
    if (adv2) begin
      ent_q <= ent_d;
      c2_q  <= c1_q;
    end
  end

  assign valid_o = v2_q;
  assign ent_o   = ent_q;
  assign coord_o = c2_q;

endmodule

>>> rtl/qpr_mat_vec.sv
// ============================================================================
// qpr_mat_vec: matrix times point, three pipeline stages
// Multiply, sum with rounding offset, then shift and saturate.
// ============================================================================
module qpr_mat_vec import qpr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  ent_t   ent_i [3][3],
  input  coord_t coord_i [3],
  output logic   valid_o,
  input  logic   ready_i,
  output coord_t res_o [3]
);

  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [RndW-1:0]  rnd_t;

  logic   v3_q, v4_q, v5_q;
  prod_t  prod_q [3][3];
  sum_t   sum_q [3];
  coord_t res_q [3];

  logic   adv3, adv4, adv5;
  prod_t  prod_d [3][3];
  sum_t   sum_d [3];
  coord_t res_d [3];
  rnd_t   rnd [3];

  assign adv5    = !v5_q || ready_i;
  assign adv4    = !v4_q || adv5;
  assign adv3    = !v3_q || adv4;
  assign ready_o = adv3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = ProdW'(ent_i[i][j]) * ProdW'(coord_i[j]);
      end
      sum_d[i] = SumW'(prod_q[i][0]) + SumW'(prod_q[i][1]) + SumW'(prod_q[i][2]) + OutRnd;
      rnd[i]   = sum_q[i][SumW-1:OutSh];
      // clamp when the bits above the coordinate are not a sign extension
      if (rnd[i][RndW-1:CoordW-1] == '0 || rnd[i][RndW-1:CoordW-1] == '1) begin
        res_d[i] = rnd[i][CoordW-1:0];
      end else if (rnd[i][RndW-1]) begin
        res_d[i] = CrdMin;
      end else begin
        res_d[i] = CrdMax;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv3) v3_q <= valid_i;
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) prod_q <= prod_d;
    if (adv4) sum_q  <= sum_d;
    if (adv5) res_q  <= res_d;
  end

  assign valid_o = v5_q;
  assign res_o   = res_q;

endmodule

>>> rtl/quaternion_point_rotator.sv
// ============================================================================
// quaternion_point_rotator: rotate Q19.12 points by a Q1.14 quaternion
// Five-stage pipeline forming the rotation matrix and the rotated point.
// ============================================================================
// Throughput: one point per cycle while the output is not stalled; each of
// the five stages holds one beat and advances whenever the stage after it is
// empty or moving on.
// Reset: quaternion returns to (1,0,0,0), the identity; the pipeline empties.
// The quaternion is not normalised: a non-unit value scales and shears points.
module quaternion_point_rotator import qpr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [QuatW-1:0]  cfg_data_i,
  // input point channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CoordW-1:0] px_in_i,
  input  logic [CoordW-1:0] py_in_i,
  input  logic [CoordW-1:0] pz_in_i,
  // output point channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CoordW-1:0] px_out_o,
  output logic [CoordW-1:0] py_out_o,
  output logic [CoordW-1:0] pz_out_o
);

  quat_t  quat_q;
  coord_t coord_in [3];
  coord_t coord_mid [3];
  ent_t   ent_mid [3][3];
  coord_t res [3];
  logic   qm_ready, mid_valid, mv_ready;

  // Quaternion registers; the user must write them only while no beat is in
  // flight; the block does not enforce it. Stage one reads them unshadowed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q.w <= QuatWReset;
      quat_q.x <= '0;
      quat_q.y <= '0;
      quat_q.z <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_QUAT_W: quat_q.w <= cfg_data_i;
        CFG_QUAT_X: quat_q.x <= cfg_data_i;
        CFG_QUAT_Y: quat_q.y <= cfg_data_i;
        CFG_QUAT_Z: quat_q.z <= cfg_data_i;
        default:    quat_q   <= quat_q;
      endcase
    end
  end

  assign coord_in[0] = px_in_i;
  assign coord_in[1] = py_in_i;
  assign coord_in[2] = pz_in_i;

  // Stages 1-2: component products, then Q.20 matrix entries.
  qpr_quat_mat u_quat_mat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (qm_ready),
    .quat_i  (quat_q),
    .coord_i (coord_in),
    .valid_o (mid_valid),
    .ready_i (mv_ready),
    .ent_o   (ent_mid),
    .coord_o (coord_mid)
  );

  // Stages 3-5: nine products, row sums, round and saturate.
  qpr_mat_vec u_mat_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mv_ready),
    .ent_i   (ent_mid),
    .coord_i (coord_mid),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .res_o   (res)
  );

  // Hold the input side only when every stage is full and the output stalls.
  assign in_stall_o = !qm_ready;

  assign px_out_o = res[0];
  assign py_out_o = res[1];
  assign pz_out_o = res[2];

endmodule
